// File: sv/crlmf_pkg.sv
package crlmf_pkg;

    localparam int ADDR_W = 32;
    localparam int HELD_W = 7;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } crlmf_state_t;

    // A rule is stored as its inclusive address range and its mode.
    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic              allow;
    } rule_entry_t;

endpackage

// File: sv/crlmf_rule_ram.sv
module crlmf_rule_ram
    import crlmf_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rule_entry_t      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rule_entry_t      rd_data
);

    rule_entry_t mem [DEPTH];
    rule_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/cidr_rule_last_match_filter_core.sv
// An append item, or a check on an empty table, goes from the idle state straight to the
// finish state; a check over N stored rules passes through the scan state first.
// The rule memory is read one entry per cycle, and the block takes the next item only
// after the result of the last one is loaded into the output register.
// Reset is synchronous and active low; it clears the rule count, the state, the scan flags and the output valid flag.
// The rule memory itself is not cleared, since only entries below the rule count are read.
module cidr_rule_last_match_filter_core
    import crlmf_pkg::*;
#(
    parameter int MAX_RULES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [ADDR_W-1:0] s_address,
    input  logic [ADDR_W-1:0] s_mask,
    input  logic              s_allow,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_verdict,
    output logic              m_status,
    output logic [HELD_W-1:0] m_rules_held
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    crlmf_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              issue_done_reg, issue_done_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    logic [ADDR_W-1:0] query_reg, query_next;
    logic              verdict_reg, verdict_next;
    logic              status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_verdict_reg;
    logic              m_status_reg;
    logic [HELD_W-1:0] m_rules_held_reg;

    logic        accept;
    logic        issue;
    logic        load_out;
    logic        table_full;
    logic        last_issue;
    logic        rule_wr_en;
    rule_entry_t rule_wr_data;
    rule_entry_t rule_rd_data;
    logic        rule_match;

    assign table_full = (count_reg == CNT_W'(MAX_RULES));
    assign last_issue = (CNT_W'(scan_idx_reg) == (count_reg - CNT_W'(1)));
    assign rule_match = (query_reg >= rule_rd_data.lo) && (query_reg <= rule_rd_data.hi);

    assign rule_wr_en        = accept && (s_opcode == OP_APPEND) && !table_full;
    assign rule_wr_data.lo   = s_address & s_mask;
    assign rule_wr_data.hi   = s_address | ~s_mask;
    assign rule_wr_data.allow = s_allow;

    crlmf_rule_ram #(
        .DEPTH (MAX_RULES),
        .IDX_W (IDX_W)
    ) u_rule_ram (
        .aclk    (aclk),
        .wr_en   (rule_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (rule_wr_data),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg),
        .rd_data (rule_rd_data)
    );

    always_comb begin
        s_ready  = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                issue = !issue_done_reg;
            end
            ST_FINISH: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        accept = s_valid && s_ready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((s_opcode == OP_CHECK) && (count_reg != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_valid_reg && rd_last_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        query_next      = query_reg;
        verdict_next    = verdict_reg;
        status_next     = status_reg;
        rd_valid_next   = issue;
        rd_last_next    = issue && last_issue;
        m_valid_next    = m_valid_reg;

        if (accept) begin
            query_next      = s_address;
            verdict_next    = 1'b0;
            status_next     = STATUS_DONE;
            scan_idx_next   = '0;
            issue_done_next = 1'b0;
            if (s_opcode == OP_APPEND) begin
                if (table_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end

        if (issue) begin
            if (last_issue) begin
                issue_done_next = 1'b1;
            end else begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
        end

        if (rd_valid_reg && rule_match) begin
            verdict_next = rule_rd_data.allow;
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            rd_last_reg    <= rd_last_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        query_reg    <= query_next;
        verdict_reg  <= verdict_next;
        status_reg   <= status_next;
        if (load_out) begin
            m_verdict_reg    <= verdict_reg;
            m_status_reg     <= status_reg;
            m_rules_held_reg <= HELD_W'(count_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_status     = m_status_reg;
    assign m_rules_held = m_rules_held_reg;

endmodule

// File: sv/crlmf_checker.sv
module crlmf_checker
    import crlmf_pkg::*;
#(
    parameter int MAX_RULES = 64
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_opcode,
    input logic [ADDR_W-1:0] s_address,
    input logic [ADDR_W-1:0] s_mask,
    input logic              s_allow,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_verdict,
    input logic              m_status,
    input logic [HELD_W-1:0] m_rules_held
);

    // The block holds one item at a time, so it cannot take a second item right away.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in two consecutive cycles");

    // A refused append reports a full table and a deny verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_FULL) |->
            (m_rules_held == HELD_W'(MAX_RULES)) && !m_verdict)
        else $error("full status with wrong rule count or verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(m_status)
            && $stable(m_rules_held))
        else $error("stalled result item changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_opcode) && $stable(s_address)
            && $stable(s_mask) && $stable(s_allow))
        else $error("waiting input item changed");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind cidr_rule_last_match_filter_core crlmf_checker #(
    .MAX_RULES (MAX_RULES)
) u_crlmf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_opcode     (s_opcode),
    .s_address    (s_address),
    .s_mask       (s_mask),
    .s_allow      (s_allow),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_verdict    (m_verdict),
    .m_status     (m_status),
    .m_rules_held (m_rules_held)
);
